// ----- hdl/bdl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdl_pkg
// Shared types and codes for the bounded linked value list.
// ----------------------------------------------------------------------------
package bdl_pkg;

    // one list slot as it travels down the cell chain
    typedef struct packed {
        logic        vld;
        logic [31:0] val;
    } t_word;

    // command codes
    localparam logic [3:0] CMD_INS_FRONT  = 4'd0;
    localparam logic [3:0] CMD_INS_BACK   = 4'd1;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd2;
    localparam logic [3:0] CMD_INS_AFTER  = 4'd3;
    localparam logic [3:0] CMD_DEL_FRONT  = 4'd4;
    localparam logic [3:0] CMD_DEL_BACK   = 4'd5;
    localparam logic [3:0] CMD_DEL_BEFORE = 4'd6;
    localparam logic [3:0] CMD_DEL_AFTER  = 4'd7;
    localparam logic [3:0] CMD_READ_ALL   = 4'd8;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY       = 3'd1;
    localparam logic [2:0] ST_NOMATCH     = 3'd2;
    localparam logic [2:0] ST_NONEIGHBOR  = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;

endpackage
`default_nettype wire

// ----- hdl/bdl_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdl_cell
// One slot of the list ring: holds a word and takes its neighbour's on shift.
// ----------------------------------------------------------------------------
module bdl_cell (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_shift,
    input  wire bdl_pkg::t_word i_word,
    output bdl_pkg::t_word o_word
);
    import bdl_pkg::*;

    logic        r_vld;
    logic [31:0] r_val;

    // valid flag is control state, value is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_word.val;
        end
    end

    assign o_word = '{vld: r_vld, val: r_val};

endmodule
`default_nettype wire

// ----- hdl/bounded_doubly_linked_value_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_doubly_linked_value_list
// Ordered list of up to DEPTH 32-bit values kept in a ring of cells.
// ----------------------------------------------------------------------------
// The list sits packed from cell 0 in a chain of DEPTH cells. Commands that
// are settled at once (unused codes, insert front/back on a full list, any
// other command on an empty list) are answered from the idle state. Every
// other command holds the input while the ring (DEPTH cells plus one delay
// slot) rotates once past the controller, which searches, inserts or drops
// one word as it goes; its result is registered at the end of the rotation.
// A reply word held by a stalled output also holds the rotation.
// Read all gives one word per list entry during that rotation; every other
// command gives one word with last set at its end. No new word is taken
// while a rotation runs or while a finished word is held stalled.
module bounded_doubly_linked_value_list #(
    parameter int DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [3:0]  i_command,
    input  wire  [31:0] i_key,
    input  wire  [31:0] i_value,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_value_out,
    output logic        o_last
);
    import bdl_pkg::*;

    localparam int TW = $clog2(DEPTH + 1);
    localparam logic [TW-1:0] TDEPTH = TW'(DEPTH);

    typedef enum logic {S_IDLE, S_PASS} t_state;
    // delay between the word leaving cell 0 and the word fed back
    typedef enum logic [1:0] {M_D0, M_D1, M_D2} t_mode;

    // cell chain: w_chain[i] is cell i, w_chain[DEPTH] is the feedback
    t_word w_chain [DEPTH+1];
    t_word w_feed;
    logic  w_shift;

    assign w_chain[DEPTH] = w_feed;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        bdl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_word  (w_chain[gi+1]),
            .o_word  (w_chain[gi])
        );
    end

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [3:0]    r_cmd;
    logic [31:0]   r_key, r_val;
    logic [TW-1:0] r_t, n_t;
    logic [TW-1:0] r_cnt, n_cnt;
    t_word         r_p, n_p, r_q, n_q;
    logic          r_found, n_found, r_hit, n_hit, r_act, n_act, r_nonb, n_nonb;
    logic [31:0]   r_del, n_del;
    logic          r_ovld, n_ovld;
    logic [2:0]    r_ost, n_ost;
    logic [31:0]   r_oval, n_oval;
    logic          r_olast, n_olast;

    logic          out_free, accept, full, last_t, match;
    logic          do_ins, do_dropx, do_dropp, set_nonb, emit_rd, emit;
    t_word         x;

    assign out_free = !r_ovld || !i_stall;
    assign o_stall  = (r_state == S_PASS) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign full     = (r_cnt == TDEPTH);
    assign last_t   = (r_t == TDEPTH);

    // word at the seam; the slot after the last cell reads as empty
    always_comb begin
        x = w_chain[0];
        if (last_t) begin
            x.vld = 1'b0;
        end
    end

    assign match = (r_state == S_PASS) && x.vld && (x.val == r_key) && !r_found;

    // per-command action at the seam
    always_comb begin
        do_ins   = 1'b0;
        do_dropx = 1'b0;
        do_dropp = 1'b0;
        set_nonb = 1'b0;
        emit_rd  = 1'b0;
        case (r_cmd)
            CMD_INS_FRONT:  do_ins   = (r_t == '0) && !r_act;
            CMD_INS_BACK:   do_ins   = !x.vld && !r_act;
            CMD_INS_BEFORE: do_ins   = match && !full;
            CMD_INS_AFTER:  do_ins   = r_hit && !full;
            CMD_DEL_FRONT:  do_dropx = (r_t == '0) && !r_act;
            CMD_DEL_BACK:   do_dropp = !x.vld && !r_act;
            CMD_DEL_BEFORE: begin
                do_dropp = match && r_p.vld;
                set_nonb = match && !r_p.vld;
            end
            CMD_DEL_AFTER: begin
                do_dropx = r_hit && x.vld;
                set_nonb = r_hit && !x.vld;
            end
            CMD_READ_ALL:   emit_rd  = x.vld;
            default: ;
        endcase
    end

    assign emit    = (r_state == S_PASS) && (emit_rd || (last_t && r_cmd != CMD_READ_ALL));
    assign w_shift = (r_state == S_PASS) && (!emit || out_free);

    // next-state logic
    always_comb begin
        logic [31:0] del_now;
        logic        nonb_now;
        n_state = r_state;
        n_mode  = r_mode;
        n_t     = r_t;
        n_cnt   = r_cnt;
        n_p     = r_p;
        n_q     = r_q;
        n_found = r_found;
        n_hit   = r_hit;
        n_act   = r_act;
        n_nonb  = r_nonb;
        n_del   = r_del;
        n_ovld  = r_ovld && i_stall;
        n_ost   = r_ost;
        n_oval  = r_oval;
        n_olast = r_olast;
        w_feed  = r_p;
        del_now  = do_dropx ? x.val : (do_dropp ? r_p.val : r_del);
        nonb_now = r_nonb || set_nonb;

        // feedback word and delay line
        if (do_ins) begin
            w_feed = r_p;
            n_q    = '{vld: 1'b1, val: r_val};
            n_p    = x;
            n_mode = M_D2;
        end else if (do_dropx) begin
            w_feed = r_p;
            n_p    = '{vld: 1'b0, val: '0};
            n_mode = M_D0;
        end else if (do_dropp) begin
            w_feed = x;
            n_p    = '{vld: 1'b0, val: '0};
            n_mode = M_D0;
        end else begin
            case (r_mode)
                M_D0: w_feed = x;
                M_D1: begin
                    w_feed = r_p;
                    n_p    = x;
                end
                M_D2: begin
                    w_feed = r_q;
                    n_q    = r_p;
                    n_p    = x;
                end
                default: w_feed = x;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command > CMD_READ_ALL) begin
                        n_ovld = 1'b1; n_ost = ST_OK; n_oval = '0; n_olast = 1'b1;
                    end else if ((i_command == CMD_INS_FRONT ||
                                  i_command == CMD_INS_BACK) && full) begin
                        n_ovld = 1'b1; n_ost = ST_FULL; n_oval = '0; n_olast = 1'b1;
                    end else if (r_cnt == '0 && i_command != CMD_INS_FRONT &&
                                 i_command != CMD_INS_BACK) begin
                        n_ovld = 1'b1; n_ost = ST_EMPTY; n_oval = '0; n_olast = 1'b1;
                    end else begin
                        n_state = S_PASS;
                        n_mode  = M_D1;
                        n_t     = '0;
                        n_p     = '{vld: 1'b0, val: '0};
                        n_found = 1'b0;
                        n_hit   = 1'b0;
                        n_act   = 1'b0;
                        n_nonb  = 1'b0;
                        n_del   = '0;
                    end
                end
            end
            S_PASS: begin
                if (!w_shift) begin
                    n_mode = r_mode;
                    n_p    = r_p;
                    n_q    = r_q;
                end else begin
                    n_t     = r_t + 1'b1;
                    n_found = r_found || match;
                    n_hit   = match;
                    n_nonb  = nonb_now;
                    n_del   = del_now;
                    if (do_ins || do_dropx || do_dropp || set_nonb) begin
                        n_act = 1'b1;
                    end
                    if (do_ins) begin
                        n_cnt = r_cnt + 1'b1;
                    end else if (do_dropx || do_dropp) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                    // read-out word
                    if (emit_rd) begin
                        n_ovld  = 1'b1;
                        n_ost   = ST_OK;
                        n_oval  = x.val;
                        n_olast = (r_t == TW'(DEPTH - 1)) || !w_chain[1].vld;
                    end
                    // end of rotation
                    if (last_t) begin
                        n_state = S_IDLE;
                        if (r_cmd != CMD_READ_ALL) begin
                            n_ovld  = 1'b1;
                            n_olast = 1'b1;
                            n_oval  = '0;
                            n_ost   = ST_OK;
                            case (r_cmd)
                                CMD_INS_BEFORE, CMD_INS_AFTER: begin
                                    if (!r_found) n_ost = ST_NOMATCH;
                                    else if (!r_act && !do_ins) n_ost = ST_FULL;
                                end
                                CMD_DEL_BEFORE, CMD_DEL_AFTER: begin
                                    if (!r_found) begin
                                        n_ost = ST_NOMATCH;
                                    end else if (nonb_now) begin
                                        n_ost = ST_NONEIGHBOR;
                                    end else begin
                                        n_oval = del_now;
                                    end
                                end
                                CMD_DEL_FRONT, CMD_DEL_BACK: n_oval = del_now;
                                default: ;
                            endcase
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_D1;
            r_t     <= '0;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_hit   <= 1'b0;
            r_act   <= 1'b0;
            r_nonb  <= 1'b0;
            r_ovld  <= 1'b0;
            r_p     <= '{vld: 1'b0, val: '0};
            r_q     <= '{vld: 1'b0, val: '0};
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_t     <= n_t;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_hit   <= n_hit;
            r_act   <= n_act;
            r_nonb  <= n_nonb;
            r_ovld  <= n_ovld;
            r_p     <= n_p;
            r_q     <= n_q;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_del   <= n_del;
        r_ost   <= n_ost;
        r_oval  <= n_oval;
        r_olast <= n_olast;
        if (accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
            r_val <= i_value;
        end
    end

    assign o_valid     = r_ovld;
    assign o_status    = r_ost;
    assign o_value_out = r_oval;
    assign o_last      = r_olast;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= TDEPTH)
        else $error("list count beyond depth");

    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_chain[0].vld == (r_cnt != '0)))
        else $error("ring not packed at cell 0 while idle");

    a_no_take_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> o_stall)
        else $error("input taken during rotation");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded linked value list: a behavioural list
// model predicts every status and value word, a monitor checks each word
// leaving the block against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import bdl_pkg::*;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic        last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_command;
    logic [31:0] i_key;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [31:0] o_value_out;
    logic        o_last;

    // list model: plain ordered queue, front is the head
    logic [31:0] list_vals[$];
    t_reply      pending_replies[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    bounded_doubly_linked_value_list #(.DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_key(i_key), .i_value(i_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_value_out(o_value_out), .o_last(o_last)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #200ms;
        $display("FAIL");
        $finish;
    end

    // predict the reply words of one command
    function automatic void predict_list_op(input logic [3:0] cmd,
                                            input logic [31:0] key,
                                            input logic [31:0] val);
        int     m;
        int     nb;
        t_reply r;
        m = -1;
        r.status = ST_OK;
        r.value  = '0;
        r.last   = 1'b1;
        if (cmd > CMD_READ_ALL) begin
            pending_replies.push_back(r);
            return;
        end
        if (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK) begin
            if (list_vals.size() >= DEPTH) r.status = ST_FULL;
            else if (cmd == CMD_INS_FRONT) list_vals.push_front(val);
            else list_vals.push_back(val);
            pending_replies.push_back(r);
            return;
        end
        if (list_vals.size() == 0) begin
            r.status = ST_EMPTY;
            pending_replies.push_back(r);
            return;
        end
        case (cmd)
            CMD_DEL_FRONT: r.value = list_vals.pop_front();
            CMD_DEL_BACK:  r.value = list_vals.pop_back();
            CMD_READ_ALL: begin
                foreach (list_vals[i]) begin
                    r.value = list_vals[i];
                    r.last  = (i == list_vals.size() - 1);
                    pending_replies.push_back(r);
                end
                return;
            end
            default: begin
                foreach (list_vals[i])
                    if (m < 0 && list_vals[i] == key) m = i;
                if (m < 0) r.status = ST_NOMATCH;
                else if (cmd == CMD_INS_BEFORE || cmd == CMD_INS_AFTER) begin
                    if (list_vals.size() >= DEPTH) r.status = ST_FULL;
                    else list_vals.insert(cmd == CMD_INS_BEFORE ? m : m + 1, val);
                end else begin
                    nb = (cmd == CMD_DEL_BEFORE) ? m - 1 : m + 1;
                    if (nb < 0 || nb >= list_vals.size()) r.status = ST_NONEIGHBOR;
                    else begin
                        r.value = list_vals[nb];
                        list_vals.delete(nb);
                    end
                end
            end
        endcase
        pending_replies.push_back(r);
    endfunction

    // send one command word and wait for its acceptance
    task automatic send_word(input logic [3:0] cmd, input logic [31:0] key,
                             input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_key     <= key;
        i_value   <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_list_op(cmd, key, val);
    endtask

    // receiver stall pattern, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // check each accepted reply word
    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected word st=%0d val=%h last=%b",
                         $realtime, o_status, o_value_out, o_last);
                fail_count++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (exp_r !== {o_status, o_value_out, o_last}) begin
                    $display("%0t: expected st=%0d val=%h last=%b, got st=%0d val=%h last=%b",
                             $realtime, exp_r.status, exp_r.value, exp_r.last,
                             o_status, o_value_out, o_last);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_key();
        if (list_vals.size() > 0 && $urandom_range(99) < 75)
            return list_vals[$urandom_range(list_vals.size() - 1)];
        return $urandom_range(7);
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending_replies.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3 * DEPTH) @(posedge i_clk);
    endtask

    // corner cases: empty list, single node, extremes, full list
    task automatic test_directed();
        send_word(CMD_DEL_FRONT, 0, 0);
        send_word(CMD_READ_ALL, 0, 0);
        send_word(CMD_DEL_AFTER, 5, 0);
        send_word(CMD_INS_BEFORE, 5, 1);
        send_word(CMD_INS_BACK, 0, 32'h8000_0000);
        send_word(CMD_DEL_BEFORE, 32'h8000_0000, 0);
        send_word(CMD_DEL_AFTER, 32'h8000_0000, 0);
        send_word(CMD_INS_AFTER, 7, 0);
        send_word(CMD_INS_AFTER, 32'h8000_0000, 32'h7fff_ffff);
        send_word(CMD_INS_BEFORE, 32'h7fff_ffff, 32'hffff_ffff);
        send_word(CMD_READ_ALL, 0, 0);
        send_word(CMD_DEL_BEFORE, 32'h7fff_ffff, 0);
        send_word(CMD_DEL_AFTER, 32'h8000_0000, 0);
        send_word(CMD_DEL_BACK, 0, 0);
        send_word(CMD_DEL_FRONT, 0, 0);
        send_word(4'd9, 0, 0);
        send_word(4'd15, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < DEPTH; i++) send_word(CMD_INS_FRONT, 0, i);
        send_word(CMD_INS_BACK, 0, 0);
        send_word(CMD_INS_AFTER, 3, 0);
        send_word(CMD_INS_BEFORE, 99, 0);
        send_word(CMD_READ_ALL, 0, 0);
    endtask

    // random commands, mostly hitting present keys
    task automatic test_random(input int count);
        logic [3:0]  cmd;
        logic [31:0] val;
        for (int i = 0; i < count; i++) begin
            cmd = (list_vals.size() < 4) ? 4'($urandom_range(3)) : 4'($urandom_range(8));
            if ($urandom_range(29) == 0) cmd = 4'($urandom_range(15));
            val = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(15);
            send_word(cmd, pick_key(), val);
        end
    endtask

    // receiver held off while commands keep coming
    task automatic test_backpressure();
        hold_cycles = 400;
        test_random(12);
        send_word(CMD_READ_ALL, 0, 0);
    endtask

    initial begin
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_command = '0;
        i_key     = '0;
        i_value   = '0;
        i_stall   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(30);
        send_idle_pct = 66;
        test_random(30);
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        test_random(30);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        test_random(30);
        recv_stall_pct = 0;
        test_backpressure();
        drain();
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/bdl_pkg.sv
hdl/bdl_cell.sv
hdl/bounded_doubly_linked_value_list.sv
dv/tb_top.sv
